// File: src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/ntg_pkg.sv
// types, codes and helpers of the twiddle table generator
`timescale 1ns / 1ps
`default_nettype none
package ntg_pkg;

    localparam logic [1:0] OP_TWIST     = 2'd0;
    localparam logic [1:0] OP_INV_SCALE = 2'd1;
    localparam logic [1:0] OP_FWD_TW    = 2'd2;
    localparam logic [1:0] OP_INV_TW    = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ROOT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    localparam logic [31:0] MODULUS_RESET = 32'd1073692673;
    localparam logic [31:0] ROOT_RESET    = 32'd236231;

    localparam logic [2:0] STEP_CHECK = 3'd2;
    localparam logic [2:0] STEP_TABLE = 3'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] index;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        SRC_ONE, SRC_ROOT, SRC_N, SRC_P, SRC_Q, SRC_T, SRC_U
    } t_src;

    typedef enum logic [1:0] {
        E_N, E_MP2, E_IDX, E_TW
    } t_esel;

    typedef enum logic [1:0] {
        D_P, D_Q, D_T, D_U
    } t_dst;

    typedef struct packed {
        t_src  src_a;
        t_src  src_b;
        t_esel esel;
        logic  is_mul;
        t_dst  dst;
        logic  last;
    } t_uop;

    typedef struct packed {
        logic capture;
        logic go;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic bad_root;
        logic small_mod;
        logic idx_bad;
    } t_stat;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_CHECK, ST_FINISH
    } t_state;

    function automatic t_uop mk_uop(t_src a, t_src b, t_esel e, logic m, t_dst d, logic l);
        t_uop u;
        u.src_a  = a;
        u.src_b  = b;
        u.esel   = e;
        u.is_mul = m;
        u.dst    = d;
        u.last   = l;
        return u;
    endfunction

    // micro program: steps 0..2 check the root, later steps build the entry
    function automatic t_uop f_uop(logic [1:0] op, logic [2:0] step);
        t_uop u;
        u = mk_uop(SRC_ONE, SRC_ROOT, E_N, 1'b1, D_P, 1'b0);
        unique case (step)
            3'd0: u = mk_uop(SRC_ONE, SRC_ROOT, E_N, 1'b1, D_P, 1'b0);
            3'd1: u = mk_uop(SRC_ONE, SRC_P, E_N, 1'b0, D_T, 1'b0);
            3'd2: u = mk_uop(SRC_T, SRC_T, E_N, 1'b1, D_U, 1'b0);
            3'd3: begin
                unique case (op)
                    OP_TWIST:     u = mk_uop(SRC_ONE, SRC_P, E_IDX, 1'b0, D_U, 1'b1);
                    OP_INV_SCALE: u = mk_uop(SRC_ONE, SRC_N, E_N, 1'b1, D_T, 1'b0);
                    OP_FWD_TW:    u = mk_uop(SRC_ONE, SRC_P, E_TW, 1'b0, D_U, 1'b1);
                    default:      u = mk_uop(SRC_ONE, SRC_P, E_MP2, 1'b0, D_Q, 1'b0);
                endcase
            end
            3'd4: begin
                if (op == OP_INV_SCALE) begin
                    u = mk_uop(SRC_ONE, SRC_T, E_MP2, 1'b0, D_T, 1'b0);
                end else begin
                    u = mk_uop(SRC_ONE, SRC_Q, E_TW, 1'b0, D_U, 1'b1);
                end
            end
            3'd5: u = mk_uop(SRC_ONE, SRC_P, E_MP2, 1'b0, D_Q, 1'b0);
            3'd6: u = mk_uop(SRC_ONE, SRC_Q, E_IDX, 1'b0, D_U, 1'b0);
            default: u = mk_uop(SRC_T, SRC_U, E_N, 1'b1, D_U, 1'b1);
        endcase
        return u;
    endfunction

    // one bit of an interleaved modular multiply, a below m
    function automatic logic [31:0] f_modstep(logic [31:0] r, logic [31:0] a, logic b,
                                              logic [31:0] m);
        logic [32:0] x;
        x = {r, 1'b0};
        if (x >= {1'b0, m}) x = x - {1'b0, m};
        if (b) x = x + {1'b0, a};
        if (x >= {1'b0, m}) x = x - {1'b0, m};
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

// File: src/ntg_ctrl.sv
// controller state machine sequencing the micro program
`timescale 1ns / 1ps
`default_nettype none
module ntg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    i_op,
    input  wire ntg_pkg::t_stat i_stat,
    output ntg_pkg::t_cmd      o_cmd,
    output logic               busy,
    output logic               o_done,
    output logic [1:0]         o_status
);
    import ntg_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_op, n_op;
    logic [1:0] r_status, n_status;
    t_uop       w_uop;

    assign w_uop = f_uop(r_op, r_step);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_op     = r_op;
        n_status = r_status;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op     = i_op;
                    n_step   = 3'd0;
                    n_status = STATUS_OK;
                    if (i_stat.small_mod) begin
                        n_status = STATUS_BAD_ROOT;
                        n_state  = ST_FINISH;
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_stat.done) begin
                    priority if (w_uop.last) begin
                        n_state = ST_FINISH;
                    end else if (r_step == STEP_CHECK) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_step  = r_step + 3'd1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_CHECK: begin
                priority if (i_stat.bad_root) begin
                    n_status = STATUS_BAD_ROOT;
                    n_state  = ST_FINISH;
                end else if (i_stat.idx_bad) begin
                    n_status = STATUS_BAD_INDEX;
                    n_state  = ST_FINISH;
                end else begin
                    n_step  = STEP_TABLE;
                    n_state = ST_ISSUE;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy          = (r_state != ST_IDLE);
        o_done        = (r_state == ST_FINISH);
        o_status      = r_status;
        o_cmd.capture = (r_state == ST_IDLE) && start;
        o_cmd.go      = (r_state == ST_ISSUE);
        o_cmd.uop     = w_uop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= 3'd0;
            r_op     <= OP_TWIST;
            r_status <= STATUS_OK;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_op     <= n_op;
            r_status <= n_status;
        end
    end

endmodule
`default_nettype wire

// File: src/ntg_datapath.sv
// datapath: serial modular multipliers, exponent engine and operand registers
`timescale 1ns / 1ps
`default_nettype none
module ntg_datapath #(
    parameter int RING_SIZE = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ntg_pkg::t_cmd i_cmd,
    input  wire ntg_pkg::t_item i_item,
    input  wire logic [31:0]   i_modulus,
    input  wire logic [31:0]   i_root,
    output ntg_pkg::t_stat     o_stat,
    output logic [31:0]        o_value
);
    import ntg_pkg::*;

    localparam int LOGN = $clog2(RING_SIZE);
    localparam int EW   = LOGN + 1;
    localparam int WW   = 13 + LOGN;

    logic [31:0]   r_p, r_q, r_t, r_u;
    logic [31:0]   r_acc, r_base, r_e, r_ra, r_rb;
    logic [11:0]   r_idx;
    logic [EW-1:0] r_tw;
    logic          r_idx_bad;
    logic [4:0]    r_cnt;
    logic          r_run, r_pass, r_done, r_mul;
    t_dst          r_dst;

    logic [12:0]   w_k1, w_j;
    logic [3:0]    w_s;
    logic [WW-1:0] w_tw;
    logic          w_idx_bad;
    logic [31:0]   w_a, w_b, w_e, w_ra, w_rb, w_wval;
    logic          w_bit, w_wr;

    // exponent of the twiddle entries: j * N / 2^s
    always_comb begin
        w_k1 = {1'b0, i_item.index} + 13'd1;
        w_s  = 4'd0;
        for (int i = 0; i < 13; i++) begin
            if (w_k1[i]) w_s = 4'(i);
        end
        w_j  = w_k1 ^ (13'd1 << w_s);
        w_tw = (WW'(w_j) << LOGN) >> w_s;
        if (i_item.op == OP_TWIST || i_item.op == OP_INV_SCALE) begin
            w_idx_bad = 32'(i_item.index) >= 32'(RING_SIZE);
        end else begin
            w_idx_bad = 32'(i_item.index) >= 32'(RING_SIZE - 1);
        end
    end

    function automatic logic [31:0] f_src(t_src s, logic [31:0] root, logic [31:0] p,
                                          logic [31:0] q, logic [31:0] t, logic [31:0] u);
        logic [31:0] v;
        unique case (s)
            SRC_ONE:  v = 32'd1;
            SRC_ROOT: v = root;
            SRC_N:    v = 32'(RING_SIZE);
            SRC_P:    v = p;
            SRC_Q:    v = q;
            SRC_T:    v = t;
            SRC_U:    v = u;
            default:  v = 32'd1;
        endcase
        return v;
    endfunction

    always_comb begin
        w_a = f_src(i_cmd.uop.src_a, i_root, r_p, r_q, r_t, r_u);
        w_b = f_src(i_cmd.uop.src_b, i_root, r_p, r_q, r_t, r_u);
        unique case (i_cmd.uop.esel)
            E_N:     w_e = 32'(RING_SIZE);
            E_MP2:   w_e = i_modulus - 32'd2;
            E_IDX:   w_e = 32'(r_idx);
            E_TW:    w_e = 32'(r_tw);
            default: w_e = 32'd0;
        endcase
        w_bit  = r_base[~r_cnt];
        w_ra   = f_modstep(r_ra, r_acc, w_bit, i_modulus);
        w_rb   = f_modstep(r_rb, r_base, w_bit, i_modulus);
        w_wr   = 1'b0;
        w_wval = r_acc;
        if (r_run && !r_pass && !r_mul && r_e == 32'd0) begin
            w_wr = 1'b1;
        end
        if (r_run && r_pass && r_mul && r_cnt == 5'd31) begin
            w_wr   = 1'b1;
            w_wval = w_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pass <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_wr;
            if (i_cmd.go) begin
                r_run  <= 1'b1;
                r_pass <= 1'b0;
            end else if (r_run) begin
                if (w_wr) begin
                    r_run  <= 1'b0;
                    r_pass <= 1'b0;
                end else if (!r_pass) begin
                    r_pass <= 1'b1;
                end else if (r_cnt == 5'd31) begin
                    r_pass <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx     <= i_item.index;
            r_tw      <= w_tw[EW-1:0];
            r_idx_bad <= w_idx_bad;
        end
        if (i_cmd.go) begin
            r_acc  <= w_a;
            r_base <= w_b;
            r_e    <= w_e;
            r_mul  <= i_cmd.uop.is_mul;
            r_dst  <= i_cmd.uop.dst;
        end else if (r_run && !r_pass) begin
            r_cnt <= 5'd0;
            r_ra  <= 32'd0;
            r_rb  <= 32'd0;
        end else if (r_run && r_pass) begin
            r_ra  <= w_ra;
            r_rb  <= w_rb;
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31 && !r_mul) begin
                if (r_e[0]) r_acc <= w_ra;
                r_base <= w_rb;
                r_e    <= r_e >> 1;
            end
        end
        if (w_wr) begin
            unique case (r_dst)
                D_P:     r_p <= w_wval;
                D_Q:     r_q <= w_wval;
                D_T:     r_t <= w_wval;
                default: r_u <= w_wval;
            endcase
        end
    end

    always_comb begin
        o_stat.done      = r_done;
        o_stat.bad_root  = !((r_t == i_modulus - 32'd1) && (r_u == 32'd1));
        o_stat.small_mod = (i_modulus < 32'd3);
        o_stat.idx_bad   = r_idx_bad;
        o_value          = r_u;
    end

endmodule
`default_nettype wire

// File: src/ntt_twiddle_table_generator_top.sv
// top level: register port, controller and datapath of the twiddle generator
// for a modulus below 3 the strobe comes in the cycle after the item; otherwise the root
// is checked first, a bad root or index ends the item there, and else the entry is built
// (inverse scale: two exponentiations by modulus-2 and one by the index)
// one item at a time, the next accepted in the cycle after the strobe; results never stall
// synchronous active-low reset clears the controller and loads the default modulus and root
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ntt_twiddle_table_generator_top #(
    parameter int RING_SIZE = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire ntg_pkg::t_item i_item,
    output logic               busy,
    output logic               o_done,
    output ntg_pkg::t_result   o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ntg_pkg::*;

    logic [31:0] r_modulus, r_root, w_value;
    logic [1:0]  w_status;
    t_cmd        w_cmd;
    t_stat       w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
            r_root    <= ROOT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_root <= pwdata;
            end else begin
                r_modulus <= pwdata;
            end
        end
    end

    assign prdata = paddr[2] ? r_root : r_modulus;
    assign pready = 1'b1;

    ntg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_item.op),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_status (w_status)
    );

    ntg_datapath #(
        .RING_SIZE (RING_SIZE)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_item    (i_item),
        .i_modulus (r_modulus),
        .i_root    (r_root),
        .o_stat    (w_stat),
        .o_value   (w_value)
    );

    assign o_result.status = w_status;
    assign o_result.value  = (w_status == STATUS_OK) ? w_value : 32'd0;

    `ASSERT_SAME(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_done && o_result.status != STATUS_OK, o_result.value == 32'd0)

endmodule
`default_nettype wire

// File: tb/ntt_twiddle_table_generator_top_tb.sv
// testbench of the twiddle table generator: directed and random requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module ntt_twiddle_table_generator_top_tb;
    import ntg_pkg::*;

    localparam int unsigned RING_N = 4096;
    localparam logic [2:0] ADDR_MODULUS = 3'd0;
    localparam logic [2:0] ADDR_ROOT = 3'd4;
    localparam int STALL_LIMIT = 60000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_item i_item;
    logic busy;
    logic o_done;
    t_result o_result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    logic [31:0] cfg_modulus;
    logic [31:0] cfg_root;
    t_result entries_due[$];
    int n_errors = 0;
    int sender_idle_pct;
    int quiet_cycles = 0;

    ntt_twiddle_table_generator_top #(.RING_SIZE(RING_N)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
        .o_done(o_done), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic t_result twiddle_entry(t_item it, logic [31:0] md, logic [31:0] rt);
        t_result r;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] w;
        logic [31:0] k1;
        int s;
        m = {32'd0, md};
        n = RING_N;
        r.value = 32'd0;
        r.status = STATUS_OK;
        if (m < 3) begin
            r.status = STATUS_BAD_ROOT;
        end else if (pow_mod(rt, 2 * n, m) != 1 || pow_mod(rt, n, m) != m - 1) begin
            r.status = STATUS_BAD_ROOT;
        end else if (it.op == OP_TWIST || it.op == OP_INV_SCALE) begin
            if (it.index >= n) begin
                r.status = STATUS_BAD_INDEX;
            end else if (it.op == OP_TWIST) begin
                r.value = 32'(pow_mod(rt, it.index, m));
            end else begin
                w = pow_mod(pow_mod(rt, m - 2, m), it.index, m);
                r.value = 32'((pow_mod(n, m - 2, m) * w) % m);
            end
        end else if (it.index >= n - 1) begin
            r.status = STATUS_BAD_INDEX;
        end else begin
            k1 = it.index + 1;
            s = 0;
            while (s < 31 && (k1 >> (s + 1)) != 0) s++;
            w = pow_mod(rt, 2, m);
            if (it.op == OP_INV_TW) w = pow_mod(w, m - 2, m);
            r.value = 32'(pow_mod(w, (k1 - (32'd1 << s)) * (n >> (s + 1)), m));
        end
        return r;
    endfunction

    function automatic bit is_prime(logic [63:0] m);
        logic [63:0] d;
        logic [63:0] x;
        logic [63:0] bases[3];
        int r;
        bit hit;
        bases = '{64'd2, 64'd7, 64'd61};
        if (m < 2) return 0;
        if (m < 4) return 1;
        if (m[0] == 0) return 0;
        d = m - 1;
        r = 0;
        while (d[0] == 0) begin
            d = d >> 1;
            r++;
        end
        foreach (bases[i]) begin
            if (bases[i] % m == 0) continue;
            x = pow_mod(bases[i], d, m);
            if (x == 1 || x == m - 1) continue;
            hit = 0;
            for (int t = 1; t < r; t++) begin
                x = (x * x) % m;
                if (x == m - 1) hit = 1;
            end
            if (!hit) return 0;
        end
        return 1;
    endfunction

    // prime congruent to one mod 2N, searched from k upward or downward, and a primitive 2N-th root of unity
    task automatic find_field(int unsigned k, bit down, output logic [31:0] md,
                              output logic [31:0] rt);
        logic [63:0] m;
        logic [63:0] p;
        m = 0;
        while (1) begin
            m = 64'(k) * (2 * RING_N) + 1;
            if (is_prime(m)) break;
            k = down ? k - 1 : k + 1;
        end
        for (int g = 2; g < 1000; g++) begin
            p = pow_mod(g, (m - 1) / (2 * RING_N), m);
            if (pow_mod(p, RING_N, m) == m - 1) begin
                md = m[31:0];
                rt = p[31:0];
                return;
            end
        end
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_MODULUS) cfg_modulus = data;
        else cfg_root = data;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (entries_due.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_field(logic [31:0] md, logic [31:0] rt);
        drain();
        reg_write(ADDR_MODULUS, md);
        reg_write(ADDR_ROOT, rt);
    endtask

    task automatic send_item(logic [1:0] op, logic [11:0] index);
        t_item it;
        it.op = op;
        it.index = index;
        if (int'($urandom_range(99)) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(99)) < sender_idle_pct);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        entries_due = {entries_due, twiddle_entry(it, cfg_modulus, cfg_root)};
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (entries_due.size() == 0) begin
                $error("result with none expected: value %0h status %0d",
                       o_result.value, o_result.status);
                n_errors++;
            end else begin
                want = entries_due.pop_front();
                if (o_result.value !== want.value) begin
                    $error("value: expected %0h actual %0h", want.value, o_result.value);
                    n_errors++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_result.status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_boundaries();
        logic [11:0] idx[8];
        idx = '{12'd0, 12'd1, 12'd2, 12'd6, 12'd2047, 12'd4094, 12'd4095, 12'd2730};
        for (int op = 0; op < 4; op++) begin
            foreach (idx[i]) begin
                if (i < 6 || op[1]) send_item(op[1:0], idx[i]);
            end
        end
    endtask

    task automatic test_bad_roots();
        set_field(MODULUS_RESET, 32'd0);
        send_item(OP_TWIST, 12'd5);
        send_item(OP_FWD_TW, 12'd4095);
        set_field(MODULUS_RESET, 32'hFFFF_FFFF);
        send_item(OP_INV_SCALE, 12'd3);
        set_field(MODULUS_RESET, 32'd1);
        send_item(OP_INV_TW, 12'd0);
        for (int m = 0; m < 3; m++) begin
            set_field(m, ROOT_RESET);
            send_item(OP_TWIST, 12'd1);
            send_item(OP_INV_SCALE, 12'd4095);
        end
        set_field(32'hFFFF_FFFF, ROOT_RESET);
        send_item(OP_FWD_TW, 12'd9);
    endtask

    task automatic test_unreduced_root();
        set_field(MODULUS_RESET, ROOT_RESET + MODULUS_RESET);
        for (int op = 0; op < 4; op++) send_item(op[1:0], 12'd77);
    endtask

    task automatic test_random(int n_items, int idle_pct, logic [31:0] md, logic [31:0] rt);
        logic [63:0] alt;
        logic [11:0] index;
        sender_idle_pct = idle_pct;
        alt = pow_mod(rt, 2 * $urandom_range(0, RING_N - 1) + 1, md);
        set_field(md, alt[31:0]);
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(9))
                0: index = 12'hFFF - 12'($urandom_range(1));
                1: index = (12'd1 << $urandom_range(11)) - 12'($urandom_range(1));
                default: index = 12'($urandom_range(4095));
            endcase
            send_item(2'($urandom_range(3)), index);
        end
    endtask

    initial begin
        logic [31:0] lo_mod;
        logic [31:0] lo_root;
        logic [31:0] hi_mod;
        logic [31:0] hi_root;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_modulus = MODULUS_RESET;
        cfg_root = ROOT_RESET;
        sender_idle_pct = 30;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        find_field(1, 0, lo_mod, lo_root);
        find_field(32'd524287, 1, hi_mod, hi_root);

        test_boundaries();
        test_bad_roots();
        test_unreduced_root();
        set_field(hi_mod, hi_root);
        test_boundaries();
        test_random(520, 30, MODULUS_RESET, ROOT_RESET);
        test_random(520, 85, hi_mod, hi_root);
        test_random(260, 0, lo_mod, lo_root);
        test_random(180, 0, MODULUS_RESET, ROOT_RESET);
        drain();
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
